// ===== hw/rtl/cld_pkg.sv =====
// Shared types, constants and the key table for the content-length deframer.
package cld_pkg;

   // Defaults for the top-level parameters
   localparam int LENGTH_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_MAX_BODY = 1'b0;
   localparam logic [CSR_DATA_W-1:0] MAX_BODY_RESET = '1;

   // Stream widths
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 8;
   localparam int RSP_USER_W = 2;

   // Characters
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   // Key length in characters
   localparam logic [3:0] KEY_LEN = 4'd15;

   typedef enum logic [1:0] {
      KIND_BODY      = 2'd0,
      KIND_EMPTY     = 2'd1,
      KIND_MISSING   = 2'd2,
      KIND_TOO_LARGE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_BODY,
      PH_DISCARD
   } phase_type;

   typedef enum logic [1:0] {
      SUB_KEY,
      SUB_SPACE,
      SUB_DIGITS,
      SUB_IGNORE
   } sub_type;

   // One result word as it travels through the queue
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } cmd_type;

   // Lower-case key text "content-length:"
   function automatic logic [7:0] key_char(input logic [3:0] pos);
      logic [7:0] ch;
      unique case (pos)
         4'd0:    ch = 8'h63; // c
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h6C; // l
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         4'd14:   ch = 8'h3A; // :
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== hw/rtl/content_length_deframer.sv =====
// Top level of the content-length deframer: stream ports, register port, wiring.
//
// The req stream carries raw bytes of header-framed messages, one byte per
// word. The parser finds a "content-length:" header line, and after the
// blank line that closes the header block passes that many body bytes to
// the rsp stream, tlast on the final one. A zero length gives one empty
// word; a missing length or one above max_body_length gives one error word
// (tlast set) and the over-long body is dropped. tuser carries the word kind.
// Throughput: one byte per cycle, sustained while rsp_tready stays high. Every
// byte is parsed in the cycle it is accepted; the word it causes, if any,
// enters the queue at that edge and moves to the output register once that
// register is empty or being drained, and from there it shows on rsp.
// Stalls: a queue of QUEUE_DEPTH words plus the output register absorb a
// stalled receiver; req_tready falls only when the queue is full.
// Reset: the parser returns to the start of a header block, the queue and
// output register empty, and max_body_length returns to all ones.
// Register 0 (byte address 0): max_body_length, 32 bits, read/write.
module content_length_deframer #(
   parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = cld_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // data_byte[7:0]
   input  logic [cld_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // body_byte[7:0]
   output logic [cld_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind[1:0]
   output logic [cld_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cld_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cld_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cld_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import cld_pkg::*;

   logic [CSR_DATA_W-1:0] max_len_ff;
   logic                  accept;
   logic                  push_valid;
   cmd_type               push_cmd;
   logic                  full;
   logic                  pop;
   logic                  head_valid;
   cmd_type               head_cmd;
   logic                  reg_hit;

   // Register port
   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_MAX_BODY);
   assign csr_prdata = reg_hit ? max_len_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_BODY_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit) begin
         max_len_ff <= csr_pwdata;
      end
   end

   // Accept a byte whenever the queue has room
   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   cld_front #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_tdata),
      .max_len    (max_len_ff),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   cld_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   cld_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/cld_front.sv =====
// Front end: parses header bytes, tracks the body count and emits result words.
module cld_front #(
   parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [7:0]                       in_byte,
   input  logic [cld_pkg::CSR_DATA_W-1:0]   max_len,
   output logic                             push_valid,
   output cld_pkg::cmd_type                 push_cmd
);
   import cld_pkg::*;

   localparam int CMP_W = (LENGTH_BITS > CSR_DATA_W) ? LENGTH_BITS : CSR_DATA_W;
   localparam int SUM_W = LENGTH_BITS + 4;

   phase_type              phase_ff, phase_in;
   logic [1:0]             term_ff, term_in;
   logic [3:0]             keypos_ff, keypos_in;
   sub_type                sub_ff, sub_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic                   ovf_ff, ovf_in;
   logic                   found_ff, found_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;

   logic                   is_cr, is_lf, is_digit, is_blank;
   logic [7:0]             lc;
   logic                   hdr_end, line_done, too_large, rem_last;
   logic [LENGTH_BITS-1:0] base_acc;
   logic                   base_ovf;
   logic [SUM_W-1:0]       sum;
   logic [LENGTH_BITS-1:0] digit_acc;
   logic                   digit_ovf;

   // Classify the byte and work out the decimal step
   always_comb begin
      is_cr     = (in_byte == CHAR_CR);
      is_lf     = (in_byte == CHAR_LF);
      is_digit  = (in_byte >= CHAR_ZERO) && (in_byte <= CHAR_NINE);
      is_blank  = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB);
      lc        = ((in_byte >= CHAR_UP_A) && (in_byte <= CHAR_UP_Z)) ?
                  (in_byte | CASE_BIT) : in_byte;
      hdr_end   = is_lf && (term_ff == 2'd3);
      line_done = is_lf && (term_ff == 2'd1);
      too_large = ovf_ff || (CMP_W'(acc_ff) > CMP_W'(max_len));
      rem_last  = (rem_ff[LENGTH_BITS-1:1] == '0);
      // First digit of a run restarts the value
      base_acc  = (sub_ff == SUB_SPACE) ? '0 : acc_ff;
      base_ovf  = (sub_ff == SUB_SPACE) ? 1'b0 : ovf_ff;
      sum       = (SUM_W'(base_acc) << 3) + (SUM_W'(base_acc) << 1) +
                  SUM_W'(in_byte[3:0]);
      if (base_ovf || (sum[SUM_W-1:LENGTH_BITS] != '0)) begin
         digit_acc = '1;
         digit_ovf = 1'b1;
      end else begin
         digit_acc = sum[LENGTH_BITS-1:0];
         digit_ovf = 1'b0;
      end
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            if (accept && hdr_end && found_ff) begin
               if (too_large) begin
                  phase_in = PH_DISCARD;
               end else if (acc_ff != '0) begin
                  phase_in = PH_BODY;
               end
            end
         end
         PH_BODY, PH_DISCARD: begin
            if (accept && rem_last) begin
               phase_in = PH_HEADER;
            end
         end
         default: phase_in = PH_HEADER;
      endcase
   end

   // Parser datapath and result words
   always_comb begin
      term_in    = term_ff;
      keypos_in  = keypos_ff;
      sub_in     = sub_ff;
      acc_in     = acc_ff;
      ovf_in     = ovf_ff;
      found_in   = found_ff;
      rem_in     = rem_ff;
      push_valid = 1'b0;
      push_cmd   = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_BODY: begin
               if (rem_ff != '0) begin
                  rem_in = rem_ff - 1'b1;
               end
               push_valid    = 1'b1;
               push_cmd.kind = KIND_BODY;
               push_cmd.data = in_byte;
               push_cmd.last = rem_last;
            end
            PH_DISCARD: begin
               if (rem_ff != '0) begin
                  rem_in = rem_ff - 1'b1;
               end
            end
            default: begin
               if (hdr_end) begin
                  // End of header block: clear parse state and decide
                  term_in       = 2'd0;
                  keypos_in     = '0;
                  sub_in        = SUB_KEY;
                  acc_in        = '0;
                  ovf_in        = 1'b0;
                  found_in      = 1'b0;
                  push_cmd.last = 1'b1;
                  if (!found_ff) begin
                     push_valid    = 1'b1;
                     push_cmd.kind = KIND_MISSING;
                  end else if (too_large) begin
                     push_valid    = 1'b1;
                     push_cmd.kind = KIND_TOO_LARGE;
                     rem_in        = acc_ff;
                  end else if (acc_ff == '0) begin
                     push_valid    = 1'b1;
                     push_cmd.kind = KIND_EMPTY;
                  end else begin
                     rem_in = acc_ff;
                  end
               end else if (line_done) begin
                  term_in   = 2'd2;
                  keypos_in = '0;
                  sub_in    = SUB_KEY;
               end else begin
                  if (is_cr) begin
                     term_in = (term_ff == 2'd2) ? 2'd3 : 2'd1;
                  end else begin
                     term_in = 2'd0;
                  end
                  case (sub_ff)
                     SUB_KEY: begin
                        if ((keypos_ff != KEY_LEN) && (lc == key_char(keypos_ff))) begin
                           keypos_in = keypos_ff + 1'b1;
                           if (keypos_ff == KEY_LEN - 1'b1) begin
                              sub_in = SUB_SPACE;
                           end
                        end else begin
                           sub_in = SUB_IGNORE;
                        end
                     end
                     SUB_SPACE, SUB_DIGITS: begin
                        if (is_digit) begin
                           acc_in   = digit_acc;
                           ovf_in   = digit_ovf;
                           found_in = 1'b1;
                           sub_in   = SUB_DIGITS;
                        end else if (!(is_blank && (sub_ff == SUB_SPACE))) begin
                           sub_in = SUB_IGNORE;
                        end
                     end
                     default: sub_in = SUB_IGNORE;
                  endcase
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         term_ff   <= 2'd0;
         keypos_ff <= '0;
         sub_ff    <= SUB_KEY;
         acc_ff    <= '0;
         ovf_ff    <= 1'b0;
         found_ff  <= 1'b0;
         rem_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         term_ff   <= term_in;
         keypos_ff <= keypos_in;
         sub_ff    <= sub_in;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
         found_ff  <= found_in;
         rem_ff    <= rem_in;
      end
   end

endmodule

// ===== hw/rtl/cld_queue.sv =====
// Short result queue between the parser and the output stage.
module cld_queue #(
   parameter int DEPTH = cld_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  cld_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output cld_pkg::cmd_type  head_cmd
);
   import cld_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed words
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/cld_emit.sv =====
// Back end: output register that formats queued words onto the result stream.
module cld_emit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  cld_pkg::cmd_type                 head_cmd,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cld_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [cld_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast
);
   import cld_pkg::*;

   logic       valid_ff, valid_in;
   kind_type   kind_ff, kind_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;

   // Take a new word when the register is empty or being drained
   assign pop = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
      kind_in = head_cmd.kind;
      // Only body words carry data; every other kind closes its message
      data_in = (head_cmd.kind == KIND_BODY) ? head_cmd.data : 8'h00;
      last_in = (head_cmd.kind == KIND_BODY) ? head_cmd.last : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== verif/tb_content_length_deframer.sv =====
// Self-checking testbench for the content-length deframer: predictor, stimulus and checks.
`timescale 1ns / 100ps

module tb_content_length_deframer;
   import cld_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 10;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_BYTES = 150;
   localparam longint unsigned LENGTH_MAX = 64'h0000_0000_FFFF_FFFF;
   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_BODY = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE = 3'd4;

   // Progress through the header terminator
   localparam logic [1:0] TERM_NONE = 2'd0;
   localparam logic [1:0] TERM_CR = 2'd1;
   localparam logic [1:0] TERM_CRLF = 2'd2;
   localparam logic [1:0] TERM_CRLFCR = 2'd3;

   typedef struct {
      kind_type   kind;
      logic [7:0] data;
      logic       is_last;
   } deframed_word_type;

   // Tracks the deframer state byte by byte and holds the words still owed
   class frame_tracker;
      string             key_text = "content-length:";
      logic [31:0]       max_len;
      phase_type         ph;
      logic [1:0]        term;
      int unsigned       key_pos;
      sub_type           line_state;
      logic [31:0]       acc;
      bit                acc_ovf;
      bit                have_len;
      logic [31:0]       len;
      bit                len_ovf;
      logic [31:0]       left;
      deframed_word_type pending[$];
      int unsigned       failures;
      int unsigned       bytes_seen;
      int unsigned       words_seen;
      int unsigned       kind_count[4];

      function new();
         max_len = MAX_BODY_RESET;
         left = '0;
         restart_header();
      endfunction

      function void restart_line();
         key_pos = 0;
         line_state = SUB_KEY;
      endfunction

      function void restart_header();
         ph = PH_HEADER;
         term = TERM_NONE;
         restart_line();
         acc = '0;
         acc_ovf = 1'b0;
         have_len = 1'b0;
         len = '0;
         len_ovf = 1'b0;
      endfunction

      function void write_register(int unsigned index, logic [31:0] value);
         if (index == CSR_IDX_MAX_BODY) max_len = value;
      endfunction

      // Accumulate one decimal digit, saturating on overflow
      function void add_digit(logic [7:0] c, bit first);
         longint unsigned d;
         d = c - CHAR_ZERO;
         if (first) begin
            acc = '0;
            acc_ovf = 1'b0;
         end
         if (acc_ovf || acc > (LENGTH_MAX - d) / 10) begin
            acc = '1;
            acc_ovf = 1'b1;
         end else begin
            acc = acc * 10 + d;
         end
         len = acc;
         len_ovf = acc_ovf;
         have_len = 1'b1;
      endfunction

      function void line_char(logic [7:0] c);
         logic [7:0] lc;
         bit         digit;
         digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
         case (line_state)
            SUB_KEY: begin
               lc = (c >= CHAR_UP_A && c <= CHAR_UP_Z) ? (c | CASE_BIT) : c;
               if (key_pos < key_text.len() && lc == key_text[key_pos]) begin
                  key_pos++;
                  if (key_pos == key_text.len()) line_state = SUB_SPACE;
               end else begin
                  line_state = SUB_IGNORE;
               end
            end
            SUB_SPACE: begin
               if (digit) begin
                  add_digit(c, 1'b1);
                  line_state = SUB_DIGITS;
               end else if (c != CHAR_SPACE && c != CHAR_TAB) begin
                  line_state = SUB_IGNORE;
               end
            end
            SUB_DIGITS: begin
               if (digit) add_digit(c, 1'b0);
               else line_state = SUB_IGNORE;
            end
            default: line_state = SUB_IGNORE;
         endcase
      endfunction

      // Advance on one accepted byte and queue the word it causes, if any
      function void accept_byte(logic [7:0] c);
         deframed_word_type w;
         bytes_seen++;
         if (ph == PH_BODY) begin
            if (left != 0) left--;
            w.kind = KIND_BODY;
            w.data = c;
            w.is_last = (left == 0);
            pending.push_back(w);
            if (left == 0) restart_header();
            return;
         end
         if (ph == PH_DISCARD) begin
            if (left != 0) left--;
            if (left == 0) restart_header();
            return;
         end
         if (c == CHAR_LF && (term == TERM_CR || term == TERM_CRLFCR)) begin
            if (term == TERM_CR) begin
               term = TERM_CRLF;
               restart_line();
               return;
            end
            w.data = '0;
            w.is_last = 1'b1;
            if (!have_len) begin
               w.kind = KIND_MISSING;
               restart_header();
            end else if (len_ovf || len > max_len) begin
               w.kind = KIND_TOO_LARGE;
               left = len;
               restart_header();
               ph = PH_DISCARD;
            end else if (len == 0) begin
               w.kind = KIND_EMPTY;
               restart_header();
            end else begin
               left = len;
               restart_header();
               ph = PH_BODY;
               return;
            end
            pending.push_back(w);
            return;
         end
         if (c == CHAR_CR) term = (term == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
         else term = TERM_NONE;
         line_char(c);
      endfunction

      // Compare one received word against the oldest expectation
      function void check_word(logic [1:0] kind, logic [7:0] data, logic is_last);
         deframed_word_type w;
         words_seen++;
         if (pending.size() == 0) begin
            $display("%0t: word %0d not expected: kind=%0d byte=%02h last=%0b",
                     $time, words_seen, kind, data, is_last);
            failures++;
            return;
         end
         w = pending.pop_front();
         kind_count[w.kind]++;
         if (kind !== w.kind || data !== w.data || is_last !== w.is_last) begin
            $display("%0t: word %0d expected kind=%0d byte=%02h last=%0b,",
                     $time, words_seen, w.kind, w.data, w.is_last,
                     " got kind=%0d byte=%02h last=%0b", kind, data, is_last);
            failures++;
         end
      endfunction

      function void report_leftovers();
         foreach (pending[i]) begin
            $display("%0t: expected kind=%0d byte=%02h last=%0b, got nothing",
                     $time, pending[i].kind, pending[i].data, pending[i].is_last);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;   // data_byte[7:0]
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // body_byte[7:0]
   logic [RSP_USER_W-1:0] rsp_tuser;   // kind[1:0]
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_tracker board = new();
   logic [7:0]   outgoing[$];
   int unsigned  gap_pct;
   int unsigned  stall_pct;
   bit           calm;
   int unsigned  ready_hold;
   int unsigned  stuck_cycles;

   content_length_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Check each accepted word, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_word(rsp_tuser, rsp_tdata, rsp_tlast);
      if (ready_hold > 0) begin
         ready_hold--;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
         rsp_tready <= 1'b0;
         ready_hold = $urandom_range(19, 1) - 1;
      end else begin
         rsp_tready <= 1'b1;
         ready_hold = $urandom_range(24);
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no word moved for %0d cycles, %0d words outstanding",
                  $time, stuck_cycles, board.pending.size());
         $display("content_length_deframer: mismatch");
         $finish;
      end
   end

   function automatic void put_byte(logic [7:0] b);
      outgoing.push_back(b);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) outgoing.push_back(s[i]);
   endfunction

   function automatic void put_crlf();
      put_byte(CHAR_CR);
      put_byte(CHAR_LF);
   endfunction

   function automatic void put_line(string s);
      put_text(s);
      put_crlf();
   endfunction

   function automatic void put_random_bytes(int unsigned n);
      repeat (n) put_byte($urandom_range(255));
   endfunction

   // Printable header line that carries no length
   function automatic void put_junk_line();
      repeat ($urandom_range(12, 1)) put_byte($urandom_range(8'h7E, 8'h20));
      put_crlf();
   endfunction

   // Length line with random key case, padding, leading zeros and trailing text
   function automatic void put_length_line(int unsigned value);
      string      key = "content-length:";
      logic [7:0] ch;
      for (int i = 0; i < key.len(); i++) begin
         ch = key[i];
         if (ch >= "a" && ch <= "z" && $urandom_range(1)) ch = ch & ~CASE_BIT;
         put_byte(ch);
      end
      repeat ($urandom_range(3)) put_byte($urandom_range(1) ? CHAR_SPACE : CHAR_TAB);
      repeat ($urandom_range(2)) put_byte(CHAR_ZERO);
      put_text($sformatf("%0d", value));
      if ($urandom_range(3) == 0) put_text("; x");
      put_crlf();
   endfunction

   // Mostly well-formed messages; some noise, missing lengths and cut-off messages
   function automatic void put_random_message();
      int unsigned pick = $urandom_range(99);
      int unsigned payload_len = ($urandom_range(5) == 0) ? 0 : $urandom_range(20, 1);
      int unsigned first = outgoing.size();
      int unsigned cut;
      if (pick < 8) begin
         put_random_bytes($urandom_range(20, 1));
         return;
      end
      repeat ($urandom_range(2)) put_junk_line();
      if (pick < 16) begin
         if ($urandom_range(1)) put_line("Content-Length: none");
         put_crlf();
         return;
      end
      if ($urandom_range(3) == 0) put_length_line($urandom_range(99));
      put_length_line(payload_len);
      repeat ($urandom_range(1)) put_junk_line();
      put_crlf();
      put_random_bytes(payload_len);
      if (pick >= 92) begin
         cut = $urandom_range(outgoing.size() - 1, first + 1);
         while (outgoing.size() > cut) void'(outgoing.pop_back());
      end
   endfunction

   // Send every queued byte, with random gaps before some of them
   task automatic send_all();
      logic [7:0] b;
      while (outgoing.size() > 0) begin
         b = outgoing.pop_front();
         if (!calm && $urandom_range(99) < gap_pct) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge clock);
         end
         req_tdata <= b;
         req_tvalid <= 1'b1;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         board.accept_byte(b);
      end
   endtask

   // Hold off the sender until every owed word has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write a register, then read back max_body_length
   task automatic write_csr(logic [CSR_ADDR_W-1:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.write_register(addr >> 2, value);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= ADDR_MAX_BODY;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (csr_prdata !== board.max_len) begin
         $display("%0t: max_body_length read expected %08h, got %08h",
                  $time, board.max_len, csr_prdata);
         board.failures++;
      end
   endtask

   int unsigned gap_by_phase[RANDOM_PHASES] = '{0, 10, 40, 15, 5, 0};
   int unsigned stall_by_phase[RANDOM_PHASES] = '{30, 0, 40, 10, 20, 0};
   logic [31:0] max_by_phase[RANDOM_PHASES];
   int unsigned phase_end;

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      gap_pct = 10;
      stall_pct = 15;
      calm = 1'b0;
      ready_hold = 0;
      stuck_cycles = 0;
      max_by_phase = '{32'hFFFF_FFFF, 32'd0, 32'd8, $urandom_range(20, 1), 32'd3,
                       32'hFFFF_FFFE};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed messages with no length limit
      write_csr(ADDR_MAX_BODY, 32'hFFFF_FFFF);
      put_line("Content-Length: 3");
      put_crlf();
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(8'h80);
      put_line("content-length:0");
      put_crlf();
      // empty header block
      put_crlf();
      put_crlf();
      // key without digits
      put_line("Host: a");
      put_line("Content-Length: abc");
      put_crlf();
      // upper case key, tab and space before the digits
      put_text("CONTENT-LENGTH:");
      put_byte(CHAR_TAB);
      put_line(" 2");
      put_line("X-Other: 7");
      put_crlf();
      put_byte(8'h5A);
      put_byte(8'hA5);
      // last length line wins, also over a saturated one
      put_line("Content-Length: 9");
      put_line("content-Length: 1");
      put_crlf();
      put_byte(8'h01);
      put_line("Content-Length: 99999999999");
      put_line("Content-Length: 2");
      put_crlf();
      put_random_bytes(2);
      // text after the digits; body made of line terminators
      put_line("Content-Length: 4xyz");
      put_crlf();
      put_crlf();
      put_crlf();
      // lone CR and lone LF are plain line characters
      put_text("Content-Length: 2");
      put_byte(CHAR_CR);
      put_crlf();
      put_byte(CHAR_LF);
      put_text("Content-Length:");
      put_byte(CHAR_LF);
      put_line("5");
      put_text("Content-Len");
      put_byte(CHAR_CR);
      put_line("gth: 7");
      put_crlf();
      put_random_bytes(2);
      put_line("Content-Length: 0000000000000000003");
      put_crlf();
      put_random_bytes(3);
      put_line("Content-Lengt: 3");
      put_crlf();
      send_all();

      // Directed messages around a small limit
      drain();
      write_csr(ADDR_MAX_BODY, 32'd5);
      put_line("Content-Length: 6");
      put_crlf();
      put_random_bytes(6);
      put_line("Content-Length: 5");
      put_crlf();
      put_random_bytes(5);
      put_line("Content-Length: 0");
      put_crlf();
      send_all();

      // Zero limit; a write to an unused address changes nothing
      drain();
      write_csr(ADDR_MAX_BODY, 32'd0);
      put_line("Content-Length: 0");
      put_crlf();
      put_line("Content-Length: 1");
      put_crlf();
      put_random_bytes(1);
      send_all();
      drain();
      write_csr(ADDR_SPARE, 32'd100);
      put_line("Content-Length: 1");
      put_crlf();
      put_random_bytes(1);
      send_all();

      // Random messages over several limits and idle patterns
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         write_csr(ADDR_MAX_BODY, max_by_phase[p]);
         gap_pct = gap_by_phase[p];
         stall_pct = stall_by_phase[p];
         calm = (p == RANDOM_PHASES - 1);
         phase_end = board.bytes_seen + PHASE_BYTES;
         while (board.bytes_seen < phase_end) begin
            put_random_message();
            send_all();
         end
      end

      // Saturated length at the full limit is too large; its body is never reached
      drain();
      write_csr(ADDR_MAX_BODY, 32'hFFFF_FFFF);
      put_line("Content-Length: 4294967296");
      put_crlf();
      put_random_bytes(30);
      send_all();
      drain();

      board.report_leftovers();
      $display("Sent %0d bytes under limits from 0 to all ones; checked %0d words.",
               board.bytes_seen, board.words_seen);
      $display("Words by kind: %0d body, %0d empty, %0d missing length, %0d too large.",
               board.kind_count[KIND_BODY], board.kind_count[KIND_EMPTY],
               board.kind_count[KIND_MISSING], board.kind_count[KIND_TOO_LARGE]);
      if (board.failures == 0) begin
         $display("content_length_deframer: match");
      end else begin
         $display("content_length_deframer: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/cld_pkg.sv
hw/rtl/cld_front.sv
hw/rtl/cld_queue.sv
hw/rtl/cld_emit.sv
hw/rtl/content_length_deframer.sv
verif/tb_content_length_deframer.sv
